@@ hdl/dfhe_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dfhe_pkg: shared types, constants and code helpers
// Token opcodes, sequencer states and the fixed Huffman code constants used by
// the fixed-block deflate encoder.
// ----------------------------------------------------------------------------
package dfhe_pkg;

  typedef enum logic [1:0] {
    OP_START   = 2'd0,
    OP_LITERAL = 2'd1,
    OP_MATCH   = 2'd2,
    OP_END     = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_CODE  = 4'b0010,
    ST_PUT   = 4'b0100,
    ST_DRAIN = 4'b1000
  } state_t;

  localparam int unsigned AccW   = 38;  // 7 pending + 31 match bits
  localparam int unsigned CntW   = 6;
  localparam int unsigned FldW   = 13;  // widest field: 13 distance extra bits
  localparam int unsigned FldLenW = 4;
  localparam int unsigned NumFld = 4;

  // literal code ranges
  localparam logic [8:0] LitLowBase  = 9'h030;
  localparam logic [8:0] LitHighBase = 9'h190;
  localparam logic [7:0] LitLowMax   = 8'd143;
  localparam logic [7:0] LitHighMin  = 8'd144;

  // length code ranges
  localparam logic [8:0] LenCodeBase = 9'd257;
  localparam logic [8:0] Len7Max     = 9'd279;
  localparam logic [8:0] Len8First   = 9'd280;
  localparam logic [8:0] Len8Base    = 9'h0C0;
  localparam logic [8:0] EobCode     = 9'd256;
  localparam logic [8:0] LenMin      = 9'd3;
  localparam logic [8:0] LenMax      = 9'd258;
  localparam logic [4:0] LenMaxCode  = 5'd28;
  localparam logic [15:0] DistMax    = 16'd32768;

  // reverse the low n bits of v (Huffman codes leave MSB first)
  function automatic logic [8:0] bit_rev(input logic [8:0] v, input logic [3:0] n);
    logic [8:0] r;
    logic [3:0] k;
    r = '0;
    for (int i = 0; i < 9; i++) begin
      k = n - 4'd1 - i[3:0];
      if (i[3:0] < n) begin
        r[i] = v[k];
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

@@ hdl/deflate_fixed_huffman_encoder.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// deflate_fixed_huffman_encoder: fixed Huffman token coder
// Codes start / literal / match / end-of-block tokens with the fixed deflate
// code and packs the bit stream LSB first into output bytes.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): one token per beat. in_stall is high
//   whenever the sequencer is busy, so one token is in work at a time.
//   Output channel (out_valid / out_stall): one stream byte per beat;
//   out_last_of_item marks the final byte a token produced. Tokens that make
//   no byte (start, ignored match) produce no beat.
//   Steps per token: accept in ST_IDLE, code in ST_CODE, then each field is
//   appended in ST_PUT through the shared shifter (1 field for start/literal/
//   end, 4 for a match), then ST_DRAIN emits the output bytes and returns to
//   idle (an end-of-block flush byte returns to idle as it is emitted).
//   The rate is set by the single append shifter and the byte drain, one
//   field or one byte per cycle while the receiver does not stall.
//   The output register holds a finished byte while the next token is
//   accepted; a stalled receiver only holds up the drain phase.
//   Reset (rst_n low, synchronous) clears the pending bits, the sequencer and
//   the output valid.
// ----------------------------------------------------------------------------
module deflate_fixed_huffman_encoder
  import dfhe_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_operation,
  input  wire logic        in_final_block,
  input  wire logic [7:0]  in_literal_byte,
  input  wire logic [8:0]  in_match_length,
  input  wire logic [15:0] in_match_distance,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_byte,
  output logic             out_last_of_item
);

  state_t state_r, state_nxt;

  // latched token
  op_t         op_r;
  logic        fin_r;
  logic [7:0]  lit_r;
  logic [8:0]  len_r;
  logic [15:0] dist_r;

  // bit accumulator; bits above cnt_r are always zero
  logic [AccW-1:0] acc_r, acc_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;

  // field list built in the code cycle, consumed by the append shifter
  logic [FldW-1:0]    fld_val_r [NumFld];
  logic [FldLenW-1:0] fld_len_r [NumFld];
  logic [FldW-1:0]    fld_val_nxt [NumFld];
  logic [FldLenW-1:0] fld_len_nxt [NumFld];
  logic [1:0]         last_r, last_nxt;
  logic [1:0]         step_r, step_nxt;

  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_byte_r, out_byte_nxt;
  logic       out_last_r, out_last_nxt;

  logic in_accept;
  logic load_ok;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign load_ok   = !out_valid_r || !out_stall;

  assign out_valid        = out_valid_r;
  assign out_byte         = out_byte_r;
  assign out_last_of_item = out_last_r;

  // --------------------------------------------------------------------------
  // Code cycle: token -> up to four (value, bit count) fields
  // --------------------------------------------------------------------------
  logic [7:0]  lmin3;      // length - 3
  logic [14:0] dmin1;      // distance - 1
  logic [2:0]  lmsb;
  logic [3:0]  dmsb;
  logic [4:0]  lc;
  logic [4:0]  dc;
  logic [3:0]  lext_n, dext_n;
  logic [7:0]  lext_v, lsh;
  logic [14:0] dext_v, dsh;
  logic [8:0]  lcode, hcode;
  logic [3:0]  hlen;
  logic [8:0]  lit_code;
  logic        match_ok;

  always_comb begin
    lmin3 = 8'(len_r - LenMin);
    dmin1 = 15'(dist_r - 16'd1);
    lmsb  = '0;
    for (int i = 0; i < 8; i++) begin
      if (lmin3[i]) begin
        lmsb = 3'(i);
      end
    end
    dmsb = '0;
    for (int i = 0; i < 15; i++) begin
      if (dmin1[i]) begin
        dmsb = 4'(i);
      end
    end

    // length code: below 8 direct, else two bits after the leading one
    lsh = '0;
    if (len_r == LenMax) begin
      lc     = LenMaxCode;
      lext_n = '0;
      lext_v = '0;
    end else if (lmin3 < 8'd8) begin
      lc     = lmin3[4:0];
      lext_n = '0;
      lext_v = '0;
    end else begin
      lsh    = lmin3 >> (lmsb - 3'd2);
      lc     = {3'(lmsb - 3'd1), lsh[1:0]};
      lext_n = {1'b0, 3'(lmsb - 3'd2)};
      lext_v = lmin3 & 8'((9'd1 << lext_n) - 9'd1);
    end

    // distance code: below 4 direct, else one bit after the leading one
    dsh = '0;
    if (dmin1 < 15'd4) begin
      dc     = {3'b000, dmin1[1:0]};
      dext_n = '0;
      dext_v = '0;
    end else begin
      dsh    = dmin1 >> (dmsb - 4'd1);
      dc     = {dmsb, dsh[0]};
      dext_n = dmsb - 4'd1;
      dext_v = dmin1 & 15'((16'd1 << dext_n) - 16'd1);
    end

    lcode = LenCodeBase + {4'b0000, lc};
    if (lcode <= Len7Max) begin
      hcode = bit_rev(lcode - EobCode, 4'd7);
      hlen  = 4'd7;
    end else begin
      hcode = bit_rev(lcode - Len8First + Len8Base, 4'd8);
      hlen  = 4'd8;
    end

    if (lit_r <= LitLowMax) begin
      lit_code = bit_rev({1'b0, lit_r} + LitLowBase, 4'd8);
    end else begin
      lit_code = bit_rev({1'b0, lit_r} - {1'b0, LitHighMin} + LitHighBase, 4'd9);
    end

    match_ok = (len_r >= LenMin) && (len_r <= LenMax) &&
               (dist_r != 16'd0) && (dist_r <= DistMax);
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  logic [FldW-1:0] put_val;
  logic [FldLenW-1:0] put_len;
  logic [AccW-1:0] put_bits;

  always_comb begin
    state_nxt     = state_r;
    acc_nxt       = acc_r;
    cnt_nxt       = cnt_r;
    last_nxt      = last_r;
    step_nxt      = step_r;
    fld_val_nxt   = fld_val_r;
    fld_len_nxt   = fld_len_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;

    // shared append shifter
    put_val  = fld_val_r[step_r] & FldW'((14'd1 << fld_len_r[step_r]) - 14'd1);
    put_len  = fld_len_r[step_r];
    put_bits = {{(AccW-FldW){1'b0}}, put_val} << cnt_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          state_nxt = ST_CODE;
        end
      end

      ST_CODE: begin
        step_nxt = '0;
        last_nxt = '0;
        for (int i = 0; i < NumFld; i++) begin
          fld_val_nxt[i] = '0;
          fld_len_nxt[i] = '0;
        end
        unique case (op_r)
          OP_START: begin
            acc_nxt        = '0;
            cnt_nxt        = '0;
            fld_val_nxt[0] = {10'd0, 2'b01, fin_r};  // BFINAL, BTYPE=01
            fld_len_nxt[0] = 4'd3;
          end
          OP_LITERAL: begin
            fld_val_nxt[0] = {4'd0, lit_code};
            fld_len_nxt[0] = (lit_r <= LitLowMax) ? 4'd8 : 4'd9;
          end
          OP_MATCH: begin
            if (match_ok) begin
              last_nxt       = 2'd3;
              fld_val_nxt[0] = {4'd0, hcode};
              fld_len_nxt[0] = hlen;
              fld_val_nxt[1] = {5'd0, lext_v};
              fld_len_nxt[1] = lext_n;
              fld_val_nxt[2] = {8'd0, 5'(bit_rev({4'd0, dc}, 4'd5))};
              fld_len_nxt[2] = 4'd5;
              fld_val_nxt[3] = dext_v[FldW-1:0];
              fld_len_nxt[3] = dext_n;
            end
          end
          OP_END: begin
            fld_val_nxt[0] = '0;                      // code 256: seven zeros
            fld_len_nxt[0] = 4'd7;
          end
          default: begin
          end
        endcase
        state_nxt = ST_PUT;
      end

      ST_PUT: begin
        acc_nxt = acc_r | put_bits;
        cnt_nxt = cnt_r + {2'b00, put_len};
        if (step_r == last_r) begin
          state_nxt = ST_DRAIN;
        end else begin
          step_nxt = step_r + 2'd1;
        end
      end

      ST_DRAIN: begin
        if (load_ok) begin
          if (cnt_r >= 6'd8) begin
            out_valid_nxt = 1'b1;
            out_byte_nxt  = acc_r[7:0];
            out_last_nxt  = !((cnt_r >= 6'd16) || ((op_r == OP_END) && (cnt_r != 6'd8)));
            acc_nxt       = acc_r >> 8;
            cnt_nxt       = cnt_r - 6'd8;
          end else if ((op_r == OP_END) && (cnt_r != 6'd0)) begin
            // zero-padded partial byte
            out_valid_nxt = 1'b1;
            out_byte_nxt  = acc_r[7:0];
            out_last_nxt  = 1'b1;
            acc_nxt       = '0;
            cnt_nxt       = '0;
            state_nxt     = ST_IDLE;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      acc_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      acc_r       <= acc_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      op_r   <= op_t'(in_operation);
      fin_r  <= in_final_block;
      lit_r  <= in_literal_byte;
      len_r  <= in_match_length;
      dist_r <= in_match_distance;
    end
    fld_val_r  <= fld_val_nxt;
    fld_len_r  <= fld_len_nxt;
    last_r     <= last_nxt;
    step_r     <= step_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

endmodule
`default_nettype wire
